>>> design/rot_pkg.sv
// Shared types and constants of the occupancy tracker.
package rot_pkg;

  localparam int DW = 16;          // sample width
  localparam int KW = 17;          // cell key width (sample or deviation)
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_HISTORY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 2'd1;

  localparam logic [6:0]  MIN_HIST_RESET    = 7'd20;
  localparam logic [3:0]  BURST_LIMIT_RESET = 4'd3;
  localparam logic [16:0] SIGMA_SCALE       = 17'd97163;   // 1.4826 in Q1.16
  localparam logic [15:0] SIGMA_MIN         = 16'd26;      // 0.1 in Q8.8
  localparam logic [15:0] SIGMA_RESET       = 16'd256;
  localparam logic [4:0]  OCC_MAX           = 5'd20;
  localparam logic [18:0] EMA_BIAS          = 19'd163842;  // offset + rounding
  localparam logic [18:0] DIV5_MUL          = 19'd419431;  // ceil(2^21 / 5)
  localparam int          DIV5_SHIFT        = 21;

  localparam logic [1:0] CLS_NOISE = 2'd0;
  localparam logic [1:0] CLS_BURST = 2'd1;
  localparam logic [1:0] CLS_CONT  = 2'd2;

  typedef enum logic [2:0] {
    OP_IDLE, OP_LOAD_VAL, OP_LOAD_DEV, OP_RANK, OP_SEL_LOAD, OP_SEL
  } cell_op_t;

  typedef struct packed {
    logic                 v;
    logic signed [KW-1:0] k;
  } trav_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LDV, S_RNK1, S_SLD1, S_SEL1, S_LDD, S_RNK2, S_SLD2, S_SEL2,
    S_SIG, S_SCL, S_EMA, S_DEC, S_OUT
  } state_t;

endpackage

>>> design/robust_occupancy_tracker.sv
// Top level of the median/MAD adaptive-threshold occupancy tracker.
// One transaction in, one transaction out. The window of the last HISTORY_DEPTH
// samples lives in a ring of cells. When the fill reaches min_history, the
// median and the MAD are found by rotating every key once around the ring
// (each cell counts keys below and at its own) and rotating the selected
// key once more. That is four ring rotations; without a recompute they are
// skipped. Input is taken only when the block is idle; a finished result
// waits in the output register while the next transaction is taken.
// Configuration is always ready.
module robust_occupancy_tracker import rot_pkg::*; #(
  parameter int HISTORY_DEPTH = 100
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     in_likelihood,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_activity_class,
  output logic [4:0]             out_occupancy,
  output logic signed [15:0]     out_noise_floor_out,
  output logic [15:0]            out_noise_sigma_out,
  output logic signed [15:0]     out_smoothed_likelihood,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(HISTORY_DEPTH - 1);

  state_t state_r, state_nxt;
  cell_op_t op;

  logic [CNT_W-1:0] step_r, count_r, count_nxt;
  logic [PTR_W-1:0] ptr_r;
  logic [6:0]       min_hist_r;
  logic [3:0]       burst_lim_r;
  logic signed [15:0] x_r, ema_r, floor_r;
  logic [15:0]      sigma_r;
  logic [4:0]       occ_r;
  logic [7:0]       burst_r;
  logic [32:0]      prod_r;
  logic [37:0]      div_r;
  logic             direct_r;
  logic [1:0]       cls_r;
  logic [1:0]       cls_out_r;
  logic [4:0]       occ_out_r;
  logic signed [15:0] floor_out_r, ema_out_r;
  logic [15:0]      sigma_out_r;
  logic             out_valid_r;

  logic in_fire, last_step, recompute, out_free;

  trav_t            trav [HISTORY_DEPTH];
  logic signed [KW-1:0] res [HISTORY_DEPTH];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign last_step = (step_r == LAST_STEP);
  assign count_nxt = (count_r == FULL) ? count_r : count_r + {{(CNT_W-1){1'b0}}, 1'b1};
  assign recompute = CMP_W'(count_nxt) >= CMP_W'(min_hist_r);
  assign out_free  = !out_valid_r || out_ready;

  // window ring
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    localparam int PREV = (i + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
    rot_cell #(.CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .op       (op),
      .we       (in_fire && (ptr_r == PTR_W'(i))),
      .wdata    (in_likelihood),
      .vld      (CNT_W'(i) < count_r),
      .rank_k   (count_r >> 1),
      .trav_in  (trav[PREV]),
      .trav_out (trav[i]),
      .res      (res[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = recompute ? S_LDV : S_EMA;
      S_LDV:  state_nxt = S_RNK1;
      S_RNK1: if (last_step) state_nxt = S_SLD1;
      S_SLD1: state_nxt = S_SEL1;
      S_SEL1: if (last_step) state_nxt = S_LDD;
      S_LDD:  state_nxt = S_RNK2;
      S_RNK2: if (last_step) state_nxt = S_SLD2;
      S_SLD2: state_nxt = S_SEL2;
      S_SEL2: if (last_step) state_nxt = S_SIG;
      S_SIG:  state_nxt = S_SCL;
      S_SCL:  state_nxt = S_EMA;
      S_EMA:  state_nxt = S_DEC;
      S_DEC:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell command
  always_comb begin
    unique case (state_r)
      S_LDV:          op = OP_LOAD_VAL;
      S_LDD:          op = OP_LOAD_DEV;
      S_RNK1, S_RNK2: op = OP_RANK;
      S_SLD1, S_SLD2: op = OP_SEL_LOAD;
      S_SEL1, S_SEL2: op = OP_SEL;
      default:        op = OP_IDLE;
    endcase
  end

  // sigma scaling and EMA arithmetic
  logic [33:0] rnd;
  logic [17:0] sig_raw;
  logic [19:0] ema_sum;
  logic [16:0] quo;
  logic signed [15:0] ema_new;
  logic signed [18:0] thr_high, thr_low, ema_ext;
  logic [7:0] burst_inc;
  logic [4:0] occ_p2, occ_p6;

  assign rnd     = {1'b0, prod_r} + 34'd32768;
  assign sig_raw = rnd[33:16];
  // 4*ema + x + bias stays in 2..327677
  assign ema_sum = {{2{ema_r[15]}}, ema_r, 2'b00} + {{4{x_r[15]}}, x_r}
                   + {1'b0, EMA_BIAS};
  assign quo     = div_r[DIV5_SHIFT +: 17];
  // quo - 32768 as 16-bit signed
  assign ema_new = direct_r ? x_r : {~quo[15], quo[14:0]};

  assign ema_ext  = {{3{ema_new[15]}}, ema_new};
  assign thr_high = {{3{floor_r[15]}}, floor_r} + {2'b00, sigma_r, 1'b0};
  assign thr_low  = {{3{floor_r[15]}}, floor_r} - {3'b000, sigma_r};
  assign burst_inc = (burst_r == 8'hFF) ? burst_r : burst_r + 8'd1;
  assign occ_p2   = (occ_r + 5'd2 > OCC_MAX) ? OCC_MAX : occ_r + 5'd2;
  assign occ_p6   = (occ_r + 5'd6 > OCC_MAX) ? OCC_MAX : occ_r + 5'd6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      ptr_r       <= '0;
      count_r     <= '0;
      min_hist_r  <= MIN_HIST_RESET;
      burst_lim_r <= BURST_LIMIT_RESET;
      ema_r       <= '0;
      floor_r     <= '0;
      sigma_r     <= SIGMA_RESET;
      occ_r       <= '0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_HISTORY: min_hist_r  <= cfg_wdata;
          REG_BURST_LIMIT: burst_lim_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      // rotation step counter
      if (state_r == S_RNK1 || state_r == S_SEL1 || state_r == S_RNK2 ||
          state_r == S_SEL2) begin
        step_r <= last_step ? '0 : step_r + {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (in_fire) begin
        ptr_r   <= (ptr_r == LAST_PTR) ? '0 : ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
        count_r <= count_nxt;
      end
      if (state_r == S_LDD) floor_r <= res[0][15:0];
      if (state_r == S_SCL) begin
        if (sig_raw > 18'd65535)            sigma_r <= 16'hFFFF;
        else if (sig_raw[15:0] < SIGMA_MIN) sigma_r <= SIGMA_MIN;
        else                                sigma_r <= sig_raw[15:0];
      end
      if (state_r == S_DEC) begin
        ema_r <= ema_new;
        if (ema_ext > thr_high) begin
          if (occ_r != 5'd0) occ_r <= occ_r - 5'd1;
          burst_r <= '0;
        end else if (ema_ext > thr_low) begin
          burst_r <= burst_inc;
          if (burst_inc > {4'b0000, burst_lim_r}) occ_r <= occ_p2;
        end else begin
          occ_r   <= occ_p6;
          burst_r <= '0;
        end
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
    end
  end

  // payload registers; the class waits in cls_r so a held result stays intact
  always_ff @(posedge clk) begin
    if (in_fire) x_r <= in_likelihood;
    if (state_r == S_SIG) prod_r <= res[0][15:0] * SIGMA_SCALE;
    if (state_r == S_EMA) begin
      div_r    <= ema_sum[18:0] * DIV5_MUL;
      direct_r <= (ema_r == 16'sd0);
    end
    if (state_r == S_DEC) begin
      if (ema_ext > thr_high)     cls_r <= CLS_NOISE;
      else if (ema_ext > thr_low) cls_r <= (burst_inc > {4'b0000, burst_lim_r}) ?
                                           CLS_BURST : CLS_NOISE;
      else                        cls_r <= CLS_CONT;
    end
    if (state_r == S_OUT && out_free) begin
      cls_out_r   <= cls_r;
      occ_out_r   <= occ_r;
      floor_out_r <= floor_r;
      sigma_out_r <= sigma_r;
      ema_out_r   <= ema_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_activity_class      = cls_out_r;
  assign out_occupancy           = occ_out_r;
  assign out_noise_floor_out     = floor_out_r;
  assign out_noise_sigma_out     = sigma_out_r;
  assign out_smoothed_likelihood = ema_out_r;

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_MAX) else $error("occupancy above limit");
  a_sigma_min: assert property (@(posedge clk) disable iff (!rst_n)
    sigma_r >= SIGMA_MIN) else $error("sigma below floor");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL) else $error("window fill overflow");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("input taken twice");
`endif

endmodule

>>> design/rot_cell.sv
// One window cell: holds a sample, ranks passing keys, picks up the selected key.
module rot_cell import rot_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic                  we,
  input  logic signed [DW-1:0]  wdata,
  input  logic                  vld,
  input  logic [CNT_W-1:0]      rank_k,
  input  trav_t                 trav_in,
  output trav_t                 trav_out,
  output logic signed [KW-1:0]  res
);

  logic signed [DW-1:0] val_r;
  logic signed [KW-1:0] key_r;
  logic signed [KW-1:0] res_r;
  trav_t                trav_r;
  logic [CNT_W-1:0]     lt_r;
  logic [CNT_W-1:0]     le_r;

  logic signed [KW-1:0] val_ext;
  logic signed [KW:0]   diff;
  logic signed [KW-1:0] dev;
  logic                 qual;

  assign val_ext = {val_r[DW-1], val_r};
  assign diff    = {val_ext[KW-1], val_ext} - {res_r[KW-1], res_r};
  // |sample - median| never exceeds 65535
  assign dev     = diff[KW] ? KW'(-diff) : diff[KW-1:0];
  // this cell holds the rank_k-th smallest key, counting from zero
  assign qual    = vld && (lt_r <= rank_k) && (le_r > rank_k);

  always_ff @(posedge clk) begin
    if (we) begin
      val_r <= wdata;
    end
    case (op)
      OP_LOAD_VAL: begin
        key_r  <= val_ext;
        trav_r <= '{v: vld, k: val_ext};
        lt_r   <= '0;
        le_r   <= '0;
      end
      OP_LOAD_DEV: begin
        key_r  <= dev;
        trav_r <= '{v: vld, k: dev};
        lt_r   <= '0;
        le_r   <= '0;
      end
      OP_RANK: begin
        if (trav_r.v) begin
          if (trav_r.k < key_r) lt_r <= lt_r + {{(CNT_W-1){1'b0}}, 1'b1};
          if (trav_r.k <= key_r) le_r <= le_r + {{(CNT_W-1){1'b0}}, 1'b1};
        end
        trav_r <= trav_in;
      end
      OP_SEL_LOAD: begin
        trav_r <= '{v: qual, k: key_r};
      end
      OP_SEL: begin
        if (trav_r.v) res_r <= trav_r.k;
        trav_r <= trav_in;
      end
      default: ;
    endcase
  end

  assign trav_out = trav_r;
  assign res      = res_r;

endmodule
